[rtl/lca_pkg.sv]
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and codes for the lowest common ancestor engine.
// ----------------------------------------------------------------------------
package lca_pkg;

  localparam int NODE_W = 10;

  typedef logic [NODE_W-1:0] node_t;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

[rtl/lca_binary_lifting_engine.sv]
// ----------------------------------------------------------------------------
// lca_binary_lifting_engine
// Binary-lifting ancestor table with a per-node depth, answering lowest
// common ancestor queries through a small sequencer over two memories.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid, in_ready, kind,       | sink
//          | node_a, node_b                  |
//  out     | out_valid, out_ready, ancestor  | source
//
// An add writes level zero of the new row from the parent; every further level is
// one table read and one table write, chained through the single table write port
// and the read latency. A query lifts the deeper node level by level (table read,
// then depth read and compare), then lifts both nodes jointly level by level, after
// a depth set-up and before the final parent read; matching nodes skip the lifts.
// Reset is synchronous; node 0 reads as zero from both memories with no clearing.
// A stalled output word holds the sequencer in its final state; in_ready is low
// whenever an item is in progress.
// ----------------------------------------------------------------------------
module lca_binary_lifting_engine #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  input  lca_pkg::node_t node_a,
  input  lca_pkg::node_t node_b,
  output logic          out_valid,
  input  logic          out_ready,
  output lca_pkg::node_t ancestor
);

  import lca_pkg::*;

  localparam int IW  = $clog2(NODES);
  localparam int LW  = $clog2(LEVELS);
  localparam int DW  = $clog2(NODES);
  localparam int TAW = IW + LW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_RD  = 4'd1;
  localparam logic [3:0] S_A_WT  = 4'd2;
  localparam logic [3:0] S_Q_DEP = 4'd3;
  localparam logic [3:0] S_Q_LT  = 4'd4;
  localparam logic [3:0] S_Q_LD  = 4'd5;
  localparam logic [3:0] S_Q_P2  = 4'd6;
  localparam logic [3:0] S_Q_LST = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]    state, state_next;
  node_t         x, x_next;
  node_t         y, y_next;
  node_t         res, res_next;
  logic [DW-1:0] dy, dy_next;
  logic [LW-1:0] k, k_next;
  logic          tz0, tz1, dz0, dz1;

  node_t         a_clip, b_clip;
  logic          add_ok;
  logic          load_out;

  node_t         tab_rn0, tab_rn1;
  logic [LW-1:0] tab_rl0, tab_rl1;
  logic          tab_we;
  node_t         tab_wn;
  logic [LW-1:0] tab_wl;
  node_t         tab_wd;
  node_t         tab_rd0, tab_rd1, tab_q0, tab_q1;

  node_t         dep_rn0, dep_rn1;
  logic          dep_we;
  node_t         dep_wn;
  logic [DW-1:0] dep_wd;
  logic [DW-1:0] dep_rd0, dep_rd1, dep_q0, dep_q1;
  logic [DW:0]   dep_inc;

  // Node indices beyond the table fold onto the sentinel.
  assign a_clip = (32'(node_a) < NODES) ? node_a : '0;
  assign b_clip = (32'(node_b) < NODES) ? node_b : '0;
  assign add_ok = (node_a != '0) && (32'(node_a) < NODES);

  // The sentinel row and depth are never written, so they are forced to zero.
  assign tab_q0 = tz0 ? '0 : tab_rd0;
  assign tab_q1 = tz1 ? '0 : tab_rd1;
  assign dep_q0 = dz0 ? '0 : dep_rd0;
  assign dep_q1 = dz1 ? '0 : dep_rd1;

  assign dep_inc = {1'b0, dep_q0} + (DW+1)'(1);

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_EMIT) && (!out_valid || out_ready);

  lca_ram #(
    .AW    (TAW),
    .WIDTH (NODE_W)
  ) u_table (
    .clk    (clk),
    .we     (tab_we),
    .waddr  ({IW'(tab_wn), tab_wl}),
    .wdata  (tab_wd),
    .raddr0 ({IW'(tab_rn0), tab_rl0}),
    .raddr1 ({IW'(tab_rn1), tab_rl1}),
    .rdata0 (tab_rd0),
    .rdata1 (tab_rd1)
  );

  lca_ram #(
    .AW    (IW),
    .WIDTH (DW)
  ) u_depth (
    .clk    (clk),
    .we     (dep_we),
    .waddr  (IW'(dep_wn)),
    .wdata  (dep_wd),
    .raddr0 (IW'(dep_rn0)),
    .raddr1 (IW'(dep_rn1)),
    .rdata0 (dep_rd0),
    .rdata1 (dep_rd1)
  );

  always_comb begin
    state_next = state;
    x_next     = x;
    y_next     = y;
    res_next   = res;
    dy_next    = dy;
    k_next     = k;

    tab_rn0 = x;
    tab_rl0 = k;
    tab_rn1 = y;
    tab_rl1 = k;
    tab_we  = 1'b0;
    tab_wn  = y;
    tab_wl  = k;
    tab_wd  = x;

    dep_rn0 = x;
    dep_rn1 = y;
    dep_we  = 1'b0;
    dep_wn  = y;
    dep_wd  = (dep_inc > (DW+1)'(NODES - 1)) ? DW'(NODES - 1) : dep_inc[DW-1:0];

    case (state)
      S_IDLE: begin
        dep_rn0 = (kind == KIND_ADD) ? b_clip : a_clip;
        dep_rn1 = b_clip;
        if (in_valid) begin
          if (kind == KIND_ADD) begin
            if (add_ok) begin
              // Level zero of the new row is the parent itself.
              tab_we     = 1'b1;
              tab_wn     = a_clip;
              tab_wl     = '0;
              tab_wd     = b_clip;
              x_next     = b_clip;
              y_next     = a_clip;
              k_next     = LW'(1);
              state_next = S_A_RD;
            end
          end else begin
            x_next = a_clip;
            y_next = b_clip;
            if (a_clip == b_clip) begin
              res_next   = a_clip;
              state_next = S_EMIT;
            end else begin
              state_next = S_Q_DEP;
            end
          end
        end
      end

      S_A_RD: begin
        // The parent's depth arrives on the first pass only.
        tab_rn0 = x;
        tab_rl0 = k - LW'(1);
        if (k == LW'(1)) begin
          dep_we = 1'b1;
          dep_wn = y;
        end
        state_next = S_A_WT;
      end

      S_A_WT: begin
        x_next = tab_q0;
        tab_we = 1'b1;
        tab_wn = y;
        tab_wl = k;
        tab_wd = tab_q0;
        if (k == LW'(LEVELS - 1)) begin
          state_next = S_IDLE;
        end else begin
          k_next     = k + LW'(1);
          state_next = S_A_RD;
        end
      end

      S_Q_DEP: begin
        if (dep_q0 < dep_q1) begin
          x_next  = y;
          y_next  = x;
          dy_next = dep_q0;
        end else begin
          dy_next = dep_q1;
        end
        k_next     = LW'(LEVELS - 1);
        tab_rn0    = x_next;
        tab_rl0    = k_next;
        state_next = S_Q_LT;
      end

      S_Q_LT: begin
        // Hold the candidate ancestor while its depth is fetched.
        res_next   = tab_q0;
        dep_rn0    = tab_q0;
        state_next = S_Q_LD;
      end

      S_Q_LD: begin
        if (dep_q0 >= dy) begin
          x_next = res;
        end
        if (k == '0) begin
          if (x_next == y) begin
            res_next   = x_next;
            state_next = S_EMIT;
          end else begin
            k_next     = LW'(LEVELS - 1);
            tab_rn0    = x_next;
            tab_rn1    = y;
            tab_rl0    = k_next;
            tab_rl1    = k_next;
            state_next = S_Q_P2;
          end
        end else begin
          k_next     = k - LW'(1);
          tab_rn0    = x_next;
          tab_rl0    = k_next;
          state_next = S_Q_LT;
        end
      end

      S_Q_P2: begin
        if (tab_q0 != tab_q1) begin
          x_next = tab_q0;
          y_next = tab_q1;
        end
        tab_rn0 = x_next;
        tab_rn1 = y_next;
        if (k == '0) begin
          tab_rl0    = '0;
          tab_rl1    = '0;
          state_next = S_Q_LST;
        end else begin
          k_next     = k - LW'(1);
          tab_rl0    = k_next;
          tab_rl1    = k_next;
          state_next = S_Q_P2;
        end
      end

      S_Q_LST: begin
        res_next   = tab_q0;
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x   <= x_next;
    y   <= y_next;
    res <= res_next;
    dy  <= dy_next;
    k   <= k_next;
    tz0 <= (tab_rn0 == '0);
    tz1 <= (tab_rn1 == '0);
    dz0 <= (dep_rn0 == '0);
    dz1 <= (dep_rn1 == '0);
    if (load_out) begin
      ancestor <= res;
    end
  end

endmodule

[rtl/lca_ram.sv]
// ----------------------------------------------------------------------------
// lca_ram
// Simple memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int AW    = 10,
  parameter int WIDTH = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  localparam int DEPTH = 2 ** AW;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
